FILE: sv/nttt_pkg.sv
package nttt_pkg;

   // Table geometry.
   localparam int MAX_TOUCHES = 16;
   localparam int COORD_BITS  = 12;

   // Fixed widths of the channel fields.
   localparam int FUNC_BITS      = 2;
   localparam int COORD_IN_BITS  = 12;
   localparam int TAG_BITS       = 8;
   localparam int COUNT_OUT_BITS = 5;

   // Derived widths.
   localparam int IDX_BITS  = (MAX_TOUCHES > 1) ? $clog2(MAX_TOUCHES) : 1;
   localparam int CNT_BITS  = $clog2(MAX_TOUCHES + 1);
   localparam int SQ_BITS   = 2 * COORD_BITS;
   localparam int DIST_BITS = 2 * COORD_BITS + 1;

   typedef logic [FUNC_BITS-1:0] func_type;

   localparam func_type FUNC_BEGIN = func_type'(0);
   localparam func_type FUNC_MOVE  = func_type'(1);
   localparam func_type FUNC_END   = func_type'(2);

   typedef struct packed {
      logic [COORD_BITS-1:0] x;
      logic [COORD_BITS-1:0] y;
      logic [TAG_BITS-1:0]   tag;
   } entry_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SCAN,
      ST_UPDATE,
      ST_RESULT
   } state_type;

endpackage

FILE: sv/nttt_req_if.sv
interface nttt_req_if;
   logic                                 valid;
   logic                                 ready;
   logic [nttt_pkg::FUNC_BITS-1:0]       func;
   logic [nttt_pkg::COORD_IN_BITS-1:0]   pos_x;
   logic [nttt_pkg::COORD_IN_BITS-1:0]   pos_y;
   logic [nttt_pkg::COORD_IN_BITS-1:0]   prev_x;
   logic [nttt_pkg::COORD_IN_BITS-1:0]   prev_y;

   modport source (output valid, func, pos_x, pos_y, prev_x, prev_y, input ready);
   modport sink   (input valid, func, pos_x, pos_y, prev_x, prev_y, output ready);
endinterface

FILE: sv/nttt_rsp_if.sv
interface nttt_rsp_if;
   logic                                 valid;
   logic                                 ready;
   logic                                 found;
   logic [nttt_pkg::TAG_BITS-1:0]        touch_tag;
   logic                                 table_full;
   logic [nttt_pkg::COUNT_OUT_BITS-1:0]  active_count;

   modport source (output valid, found, touch_tag, table_full, active_count, input ready);
   modport sink   (input valid, found, touch_tag, table_full, active_count, output ready);
endinterface

FILE: sv/nearest_touch_tracking_table_core.sv
// A begin or ignored item goes from idle to the result state, then to the output register;
// a move or end item scans every stored touch through the issue, squaring and compare stages,
// then passes the update and result states. A new item is taken only in idle, once the last
// result is in the output register; a stalled receiver holds the core in the result state.
// Reset (synchronous, active high) empties the table and clears the tag counter; the
// touch storage itself is not cleared, since entries beyond the fill count are never read.
module nearest_touch_tracking_table_core (
   input  logic       clock,
   input  logic       reset,
   nttt_req_if.sink   req_ch,
   nttt_rsp_if.source rsp_ch
);

   // Touch table. Entries below count_ff are live, oldest first.
   nttt_pkg::entry_type entry_ff [nttt_pkg::MAX_TOUCHES];
   nttt_pkg::entry_type entry_in [nttt_pkg::MAX_TOUCHES];

   nttt_pkg::state_type state_ff, state_in;

   logic [nttt_pkg::CNT_BITS-1:0] count_ff, count_in;
   logic [nttt_pkg::TAG_BITS-1:0] tag_next_ff, tag_next_in;

   // The accepted item.
   nttt_pkg::func_type              func_ff, func_in;
   logic [nttt_pkg::COORD_BITS-1:0] pos_x_ff, pos_x_in;
   logic [nttt_pkg::COORD_BITS-1:0] pos_y_ff, pos_y_in;
   logic [nttt_pkg::COORD_BITS-1:0] prev_x_ff, prev_x_in;
   logic [nttt_pkg::COORD_BITS-1:0] prev_y_ff, prev_y_in;

   // Scan sequencer: issue index, then a squaring stage, then the compare stage.
   logic [nttt_pkg::IDX_BITS-1:0]   idx_ff, idx_in;
   logic                            issue_ff, issue_in;
   logic                            s1_valid_ff, s1_valid_in;
   logic [nttt_pkg::IDX_BITS-1:0]   s1_idx_ff, s1_idx_in;
   logic [nttt_pkg::SQ_BITS-1:0]    sqx_ff, sqx_in;
   logic [nttt_pkg::SQ_BITS-1:0]    sqy_ff, sqy_in;
   logic [nttt_pkg::TAG_BITS-1:0]   s1_tag_ff, s1_tag_in;

   // Best match so far.
   logic [nttt_pkg::IDX_BITS-1:0]   best_idx_ff, best_idx_in;
   logic [nttt_pkg::DIST_BITS-1:0]  best_dist_ff, best_dist_in;
   logic [nttt_pkg::TAG_BITS-1:0]   best_tag_ff, best_tag_in;

   // Result held until the output register is free.
   logic                            res_found_ff, res_found_in;
   logic [nttt_pkg::TAG_BITS-1:0]   res_tag_ff, res_tag_in;
   logic                            res_full_ff, res_full_in;

   // Output register.
   logic                                 rsp_valid_ff, rsp_valid_in;
   logic                                 rsp_found_ff, rsp_found_in;
   logic [nttt_pkg::TAG_BITS-1:0]        rsp_tag_ff, rsp_tag_in;
   logic                                 rsp_full_ff, rsp_full_in;
   logic [nttt_pkg::COUNT_OUT_BITS-1:0]  rsp_count_ff, rsp_count_in;

   // Shared squared-distance unit signals.
   nttt_pkg::entry_type             rd_entry;
   logic [nttt_pkg::COORD_BITS-1:0] dx;
   logic [nttt_pkg::COORD_BITS-1:0] dy;
   logic [nttt_pkg::DIST_BITS-1:0]  sum_sq;
   logic [nttt_pkg::IDX_BITS-1:0]   last_idx;

   assign req_ch.ready        = (state_ff == nttt_pkg::ST_IDLE);
   assign rsp_ch.valid        = rsp_valid_ff;
   assign rsp_ch.found        = rsp_found_ff;
   assign rsp_ch.touch_tag    = rsp_tag_ff;
   assign rsp_ch.table_full   = rsp_full_ff;
   assign rsp_ch.active_count = rsp_count_ff;

   // Only meaningful while the table holds at least one touch.
   assign last_idx = nttt_pkg::IDX_BITS'(count_ff - nttt_pkg::CNT_BITS'(1));

   // Stage one of the distance unit: fetch the entry under the scan index, take absolute
   // differences and square them. Stage two adds the squares ahead of the compare.
   always_comb begin
      rd_entry = entry_ff[idx_ff];
      dx = (rd_entry.x > prev_x_ff) ? (rd_entry.x - prev_x_ff) : (prev_x_ff - rd_entry.x);
      dy = (rd_entry.y > prev_y_ff) ? (rd_entry.y - prev_y_ff) : (prev_y_ff - rd_entry.y);
      sum_sq = nttt_pkg::DIST_BITS'(sqx_ff) + nttt_pkg::DIST_BITS'(sqy_ff);
   end

   always_comb begin
      state_in     = state_ff;
      entry_in     = entry_ff;
      count_in     = count_ff;
      tag_next_in  = tag_next_ff;
      func_in      = func_ff;
      pos_x_in     = pos_x_ff;
      pos_y_in     = pos_y_ff;
      prev_x_in    = prev_x_ff;
      prev_y_in    = prev_y_ff;
      idx_in       = idx_ff;
      issue_in     = issue_ff;
      s1_valid_in  = 1'b0;
      s1_idx_in    = s1_idx_ff;
      sqx_in       = sqx_ff;
      sqy_in       = sqy_ff;
      s1_tag_in    = s1_tag_ff;
      best_idx_in  = best_idx_ff;
      best_dist_in = best_dist_ff;
      best_tag_in  = best_tag_ff;
      res_found_in = res_found_ff;
      res_tag_in   = res_tag_ff;
      res_full_in  = res_full_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ch.ready;
      rsp_found_in = rsp_found_ff;
      rsp_tag_in   = rsp_tag_ff;
      rsp_full_in  = rsp_full_ff;
      rsp_count_in = rsp_count_ff;

      unique case (state_ff)
         nttt_pkg::ST_IDLE: begin
            if (req_ch.valid) begin
               func_in   = req_ch.func;
               pos_x_in  = nttt_pkg::COORD_BITS'(req_ch.pos_x);
               pos_y_in  = nttt_pkg::COORD_BITS'(req_ch.pos_y);
               prev_x_in = nttt_pkg::COORD_BITS'(req_ch.prev_x);
               prev_y_in = nttt_pkg::COORD_BITS'(req_ch.prev_y);
               res_found_in = 1'b0;
               res_tag_in   = '0;
               res_full_in  = 1'b0;
               state_in     = nttt_pkg::ST_RESULT;
               priority if (req_ch.func == nttt_pkg::FUNC_BEGIN) begin
                  // A begin is handled at once: append at the tail or report a full table.
                  if (count_ff >= nttt_pkg::CNT_BITS'(nttt_pkg::MAX_TOUCHES)) begin
                     res_full_in = 1'b1;
                  end else begin
                     entry_in[nttt_pkg::IDX_BITS'(count_ff)].x   =
                        nttt_pkg::COORD_BITS'(req_ch.pos_x);
                     entry_in[nttt_pkg::IDX_BITS'(count_ff)].y   =
                        nttt_pkg::COORD_BITS'(req_ch.pos_y);
                     entry_in[nttt_pkg::IDX_BITS'(count_ff)].tag = tag_next_ff;
                     res_found_in = 1'b1;
                     res_tag_in   = tag_next_ff;
                     tag_next_in  = tag_next_ff + nttt_pkg::TAG_BITS'(1);
                     count_in     = count_ff + nttt_pkg::CNT_BITS'(1);
                  end
               end else if ((req_ch.func == nttt_pkg::FUNC_MOVE ||
                             req_ch.func == nttt_pkg::FUNC_END) &&
                            count_ff != '0) begin
                  idx_in   = '0;
                  issue_in = 1'b1;
                  state_in = nttt_pkg::ST_SCAN;
               end else begin
                  // Empty table or unused kind: the item is answered with nothing found.
               end
            end
         end

         nttt_pkg::ST_SCAN: begin
            if (issue_ff) begin
               s1_valid_in = 1'b1;
               s1_idx_in   = idx_ff;
               sqx_in      = nttt_pkg::SQ_BITS'(dx) * nttt_pkg::SQ_BITS'(dx);
               sqy_in      = nttt_pkg::SQ_BITS'(dy) * nttt_pkg::SQ_BITS'(dy);
               s1_tag_in   = rd_entry.tag;
               if (idx_ff == last_idx) begin
                  issue_in = 1'b0;
               end else begin
                  idx_in = idx_ff + nttt_pkg::IDX_BITS'(1);
               end
            end
            if (s1_valid_ff) begin
               // A strict compare keeps the oldest touch on a tie.
               if (s1_idx_ff == '0 || sum_sq < best_dist_ff) begin
                  best_idx_in  = s1_idx_ff;
                  best_dist_in = sum_sq;
                  best_tag_in  = s1_tag_ff;
               end
               if (s1_idx_ff == last_idx) begin
                  state_in = nttt_pkg::ST_UPDATE;
               end
            end
         end

         nttt_pkg::ST_UPDATE: begin
            res_found_in = 1'b1;
            res_tag_in   = best_tag_ff;
            if (func_ff == nttt_pkg::FUNC_END) begin
               // Removing the touch closes the gap: every later entry moves down one slot.
               for (int i = 0; i < nttt_pkg::MAX_TOUCHES - 1; i++) begin
                  if (nttt_pkg::IDX_BITS'(i) >= best_idx_ff) begin
                     entry_in[i] = entry_ff[i + 1];
                  end
               end
               count_in = count_ff - nttt_pkg::CNT_BITS'(1);
            end else begin
               entry_in[best_idx_ff].x = pos_x_ff;
               entry_in[best_idx_ff].y = pos_y_ff;
            end
            state_in = nttt_pkg::ST_RESULT;
         end

         nttt_pkg::ST_RESULT: begin
            if (!rsp_valid_ff || rsp_ch.ready) begin
               rsp_valid_in = 1'b1;
               rsp_found_in = res_found_ff;
               rsp_tag_in   = res_tag_ff;
               rsp_full_in  = res_full_ff;
               rsp_count_in = nttt_pkg::COUNT_OUT_BITS'(count_ff);
               state_in     = nttt_pkg::ST_IDLE;
            end
         end

         default: begin
            state_in = nttt_pkg::ST_IDLE;
         end
      endcase
   end

   // Control state.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= nttt_pkg::ST_IDLE;
         count_ff     <= '0;
         tag_next_ff  <= '0;
         issue_ff     <= 1'b0;
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         tag_next_ff  <= tag_next_in;
         issue_ff     <= issue_in;
         s1_valid_ff  <= s1_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Payload and table storage.
   always_ff @(posedge clock) begin
      entry_ff     <= entry_in;
      func_ff      <= func_in;
      pos_x_ff     <= pos_x_in;
      pos_y_ff     <= pos_y_in;
      prev_x_ff    <= prev_x_in;
      prev_y_ff    <= prev_y_in;
      idx_ff       <= idx_in;
      s1_idx_ff    <= s1_idx_in;
      sqx_ff       <= sqx_in;
      sqy_ff       <= sqy_in;
      s1_tag_ff    <= s1_tag_in;
      best_idx_ff  <= best_idx_in;
      best_dist_ff <= best_dist_in;
      best_tag_ff  <= best_tag_in;
      res_found_ff <= res_found_in;
      res_tag_ff   <= res_tag_in;
      res_full_ff  <= res_full_in;
      rsp_found_ff <= rsp_found_in;
      rsp_tag_ff   <= rsp_tag_in;
      rsp_full_ff  <= rsp_full_in;
      rsp_count_ff <= rsp_count_in;
   end

endmodule
